/* rtl/kvi_pkg.sv */
// Package with shared types and constants of the keyframe vector interpolator.
`default_nettype none
package kvi_pkg;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  key_slot;
    logic [31:0] key_stamp;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] query_time;
  } item_t;
endpackage
`default_nettype wire

/* rtl/kvi_queue.sv */
// Two-entry item queue between the front and the back of the interpolator.
`default_nettype none
module kvi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  kvi_pkg::item_t     push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output kvi_pkg::item_t     head
);
  kvi_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill exceeds depth");
  a_full_nopush: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full) else $error("full queue lost an item");
  a_empty_stay: assert property (@(posedge clk) disable iff (rst)
    !not_empty && !push |=> !not_empty) else $error("empty queue gained an item");
`endif
endmodule
`default_nettype wire

/* rtl/kvi_engine.sv */
// Back end: key tables, serial segment search, serial divide and interpolation.
`default_nettype none
module kvi_engine #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [6:0]   key_count,
  input  wire logic         item_valid,
  input  kvi_pkg::item_t    item,
  output logic              item_pop,
  output logic              res_valid,
  input  wire logic         res_stall,
  output logic [31:0]       res_x,
  output logic [31:0]       res_y,
  output logic [31:0]       res_z,
  output logic              res_flag
);
  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = 32 + FRAC_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_CHK0  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_RDA   = 4'd5;
  localparam logic [3:0] S_GETA  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_KEY   = 4'd11;
  localparam logic [3:0] S_KEYO  = 4'd12;
  localparam logic [3:0] S_HOLD  = 4'd13;

  logic [31:0] stamps  [MAX_KEYS];
  logic [95:0] vectors [MAX_KEYS];
  logic [IW-1:0] rd_addr;
  logic [31:0] rd_stamp;
  logic [95:0] rd_vec;

  logic [3:0]    state;
  logic [IW:0]   n;
  logic [IW:0]   idx;
  logic [31:0]   t;
  logic [31:0]   den;
  logic [NW-1:0] rem;
  logic [NW-1:0] quo;
  logic [5:0]    dcnt;
  logic [95:0]   v_lo;
  logic [1:0]    comp;
  logic signed [32:0] diff;
  logic signed [FRAC_BITS+34:0] prod;
  logic [31:0]   acc [3];
  logic          flag;

  logic [IW:0] n_clamp;
  logic [NW-1:0] rem_sh;
  logic [31:0] s_comp;
  logic [31:0] e_comp;
  logic signed [FRAC_BITS+34:0] prod_sh;

  always_comb begin
    if (key_count == 7'd0) begin
      n_clamp = (IW+1)'(1);
    end else if ({25'd0, key_count} > MAX_KEYS) begin
      n_clamp = (IW+1)'(MAX_KEYS);
    end else begin
      n_clamp = (IW+1)'(key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.opcode == kvi_pkg::OP_LOAD && {26'd0, item.key_slot} < MAX_KEYS) begin
      stamps[IW'(item.key_slot)]  <= item.key_stamp;
      vectors[IW'(item.key_slot)] <= {item.key_z, item.key_y, item.key_x};
    end
    rd_stamp <= stamps[rd_addr];
    rd_vec   <= vectors[rd_addr];
  end

  assign item_pop = (state == S_IDLE) && item_valid;

  always_comb begin
    case (comp)
      2'd0:    begin s_comp = v_lo[31:0];  e_comp = rd_vec[31:0];  end
      2'd1:    begin s_comp = v_lo[63:32]; e_comp = rd_vec[63:32]; end
      default: begin s_comp = v_lo[95:64]; e_comp = rd_vec[95:64]; end
    endcase
    rem_sh  = {rem[NW-2:0], 1'b0};
    prod_sh = prod >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      rd_addr   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && item.opcode == kvi_pkg::OP_QUERY) begin
            n       <= n_clamp;
            t       <= item.query_time;
            rd_addr <= '0;
            state   <= S_RD0;
          end
        end
        S_RD0: state <= S_CHK0;
        S_CHK0: begin
          if (n == (IW+1)'(1)) begin
            flag <= 1'b0;
            state <= S_KEYO;
          end else if (t < rd_stamp) begin
            flag <= 1'b1;
            state <= S_KEYO;
          end else begin
            idx     <= (IW+1)'(1);
            rd_addr <= IW'(1);
            state   <= S_SRCH;
          end
        end
        S_SRCH: state <= S_TEST;
        S_TEST: begin
          if (t < rd_stamp) begin
            den     <= rd_stamp;
            rd_addr <= IW'(idx - (IW+1)'(1));
            state   <= S_RDA;
          end else if (idx + (IW+1)'(1) >= n) begin
            flag    <= 1'b1;
            rd_addr <= IW'(n - (IW+1)'(1));
            state   <= S_KEY;
          end else begin
            idx     <= idx + (IW+1)'(1);
            rd_addr <= IW'(idx + (IW+1)'(1));
            state   <= S_SRCH;
          end
        end
        S_RDA: state <= S_GETA;
        S_GETA: begin
          v_lo    <= rd_vec;
          den     <= den - rd_stamp;
          rem     <= '0;
          quo     <= NW'(t - rd_stamp) << FRAC_BITS;
          dcnt    <= 6'(NW);
          rd_addr <= IW'(idx);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == 6'd0) begin
            comp  <= 2'd0;
            flag  <= 1'b0;
            state <= S_MUL;
          end else begin
            if ({rem_sh[NW-1:1], quo[NW-1]} >= NW'(den)) begin
              rem <= {rem_sh[NW-1:1], quo[NW-1]} - NW'(den);
              quo <= {quo[NW-2:0], 1'b1};
            end else begin
              rem <= {rem_sh[NW-1:1], quo[NW-1]};
              quo <= {quo[NW-2:0], 1'b0};
            end
            dcnt <= dcnt - 6'd1;
          end
        end
        S_MUL: begin
          diff  <= $signed({e_comp[31], e_comp}) - $signed({s_comp[31], s_comp});
          state <= S_SUM;
        end
        S_SUM: begin
          prod  <= $signed({1'b0, quo[FRAC_BITS:0]}) * diff;
          state <= S_OUT;
        end
        S_OUT: begin
          acc[comp] <= s_comp + prod_sh[31:0];
          if (comp == 2'd2) begin
            res_x     <= acc[0];
            res_y     <= acc[1];
            res_z     <= s_comp + prod_sh[31:0];
            res_flag  <= 1'b0;
            res_valid <= 1'b1;
            state     <= S_HOLD;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_KEY: state <= S_KEYO;
        S_KEYO: begin
          res_x     <= rd_vec[31:0];
          res_y     <= rd_vec[63:32];
          res_z     <= rd_vec[95:64];
          res_flag  <= flag;
          res_valid <= 1'b1;
          state     <= S_HOLD;
        end
        S_HOLD: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          res_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_x) && $stable(res_z))
    else $error("result changed while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> !res_valid) else $error("item taken while result pending");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != 32'd0) else $error("zero divisor");
`endif
endmodule
`default_nettype wire

/* rtl/keyframe_vector_interpolator_top.sv */
// Top level of the keyframe vector interpolator.
// Input channel: in_valid/in_stall carry load and query items. A load writes
// one key (time and vector) into a slot and gives no result. A query gives one
// result on out_valid/out_stall: the interpolated vector and range_flag.
// Items pass through a two-entry queue to the back end, which runs one item at
// a time. A query runs a segment search over the keys, then a bit-serial divide
// (one step per quotient bit, 32 + FRAC_BITS steps) and a multiply and add for
// each of the three components. End and single-key queries skip the divide.
// key_count is written through cfg_we/cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce. Reset sets it to
// one and empties the queue. The key tables are not cleared and must be loaded
// before they are queried. While out_stall is high the result holds and the
// back end waits; the queue keeps taking items until full.
`default_nettype none
module keyframe_vector_interpolator_top #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [5:0]  key_slot,
  input  wire logic [31:0] key_stamp,
  input  wire logic [31:0] key_x,
  input  wire logic [31:0] key_y,
  input  wire logic [31:0] key_z,
  input  wire logic [31:0] query_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic             range_flag
);
  logic [6:0] key_count;
  kvi_pkg::item_t in_item;
  kvi_pkg::item_t head;
  logic full;
  logic not_empty;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 7'd1;
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  assign in_item = '{opcode: opcode, key_slot: key_slot, key_stamp: key_stamp,
                     key_x: key_x, key_y: key_y, key_z: key_z, query_time: query_time};
  assign in_stall = full;

  kvi_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid), .push_item(in_item), .full(full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  kvi_engine #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk(clk), .rst(rst), .key_count(key_count), .item_valid(not_empty),
    .item(head), .item_pop(pop), .res_valid(out_valid), .res_stall(out_stall),
    .res_x(out_x), .res_y(out_y), .res_z(out_z), .res_flag(range_flag)
  );
endmodule
`default_nettype wire
